// ===== rtl/sjf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths, state encoding and controller/datapath interface structs
// for the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int MAX_JOBS_DEF = 16;

  localparam int BURST_W   = 16;  // burst time per job
  localparam int JOB_IDX_W = 4;   // job_index output field
  localparam int TIME_W    = 20;  // run clock, wait and turnaround times
  localparam int TOT_W     = 24;  // wait / turnaround totals
  localparam int FRAC_W    = 8;   // fraction bits of the averages
  localparam int FX_W      = 28;  // average output fields
  localparam int DIV_W     = TOT_W + FRAC_W;  // dividend width

  // Controller states, one-hot
  typedef enum logic [11:0] {
    ST_LOAD       = 12'b0000_0000_0001,
    ST_SCAN       = 12'b0000_0000_0010,
    ST_SCAN_FIN   = 12'b0000_0000_0100,
    ST_PICK       = 12'b0000_0000_1000,
    ST_SUM_RD     = 12'b0000_0001_0000,
    ST_SUM_ACC    = 12'b0000_0010_0000,
    ST_DIV_W      = 12'b0000_0100_0000,
    ST_DIV_W_WAIT = 12'b0000_1000_0000,
    ST_DIV_T      = 12'b0001_0000_0000,
    ST_DIV_T_WAIT = 12'b0010_0000_0000,
    ST_EMIT_RD    = 12'b0100_0000_0000,
    ST_EMIT_LD    = 12'b1000_0000_0000
  } sjf_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // store an incoming burst
    logic scan_init;  // start scheduling of the set
    logic scan_rd;    // read next entry for the min search
    logic pick;       // commit the current best job
    logic rd;         // read burst and wait stores at idx
    logic sum_acc;    // add the read entry into the totals
    logic idx_inc;
    logic idx_clr;
    logic div_start;
    logic div_sel;    // 0: wait total, 1: turnaround total
    logic load_out;   // load the output register
    logic end_set;    // clear per-set state
  } sjf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_last;
    logic pick_last;
    logic div_done;
    logic out_free;
  } sjf_stat_t;

endpackage

// ===== rtl/sjf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_div
// Restoring divider, one quotient bit per cycle, for the averages.
// ----------------------------------------------------------------------------
module sjf_div #(
  parameter int DEN_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sjf_pkg::DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0]          divisor,
  output logic                      done,
  output logic [sjf_pkg::DIV_W-1:0] quotient
);
  import sjf_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] step;
  logic [DEN_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             q_bit;

  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign q_bit   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == CNT_W'(DIV_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[DIV_W-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/sjf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_dp
// Datapath: burst and wait stores, done flags, min search, run clock,
// totals, averaging divider and output register.
// ----------------------------------------------------------------------------
module sjf_dp #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sjf_pkg::sjf_cmd_t             cmd,
  output sjf_pkg::sjf_stat_t            stat,
  input  logic [sjf_pkg::BURST_W-1:0]   burst,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sjf_pkg::JOB_IDX_W-1:0] job_index,
  output logic [sjf_pkg::BURST_W-1:0]   job_burst,
  output logic [sjf_pkg::TIME_W-1:0]    wait_time,
  output logic [sjf_pkg::TIME_W-1:0]    turnaround_time,
  output logic [sjf_pkg::FX_W-1:0]      avg_wait_fx,
  output logic [sjf_pkg::FX_W-1:0]      avg_turnaround_fx,
  output logic                          final_res
);
  import sjf_pkg::*;

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [TIME_W-1:0]  wait_mem  [MAX_JOBS];
  logic [BURST_W-1:0] burst_q;
  logic [TIME_W-1:0]  wait_q;

  logic [MAX_JOBS-1:0] done_flags;
  logic [CNT_W-1:0]    job_count;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    pick_cnt;
  logic [TIME_W-1:0]   run_clock;
  logic [TOT_W-1:0]    wait_total;
  logic [TOT_W-1:0]    turnaround_total;

  logic               cmp_en;
  logic [IDX_W-1:0]   cmp_idx;
  logic               found;
  logic [IDX_W-1:0]   best;
  logic [BURST_W-1:0] best_burst;
  logic               take;

  logic               div_sel_q;
  logic [DIV_W-1:0]   dividend;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;
  logic [FX_W-1:0]    avg_w;
  logic [FX_W-1:0]    avg_t;

  logic [TIME_W-1:0]  turn_cur;
  logic [CNT_W-1:0]   count_m1;
  logic               set_room;

  assign count_m1 = job_count - CNT_W'(1);
  assign set_room = (job_count < CNT_W'(MAX_JOBS));
  assign turn_cur = wait_q + TIME_W'(burst_q);

  assign take = cmp_en && !done_flags[cmp_idx] && (!found || (burst_q < best_burst));

  assign stat.idx_last  = (CNT_W'(idx) == count_m1);
  assign stat.pick_last = (CNT_W'(pick_cnt) == count_m1);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || out_ready;

  // Stores: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load && set_room) begin
      burst_mem[job_count[IDX_W-1:0]] <= burst;
    end
    if (cmd.scan_rd || cmd.rd) begin
      burst_q <= burst_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      wait_mem[best] <= run_clock;
    end
    if (cmd.rd) begin
      wait_q <= wait_mem[idx];
    end
  end

  // Per-set control state
  always_ff @(posedge clk) begin
    if (rst) begin
      done_flags       <= '0;
      job_count        <= '0;
      idx              <= '0;
      pick_cnt         <= '0;
      run_clock        <= '0;
      wait_total       <= '0;
      turnaround_total <= '0;
      cmp_en           <= 1'b0;
      found            <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;

      if (cmd.load && set_room) begin
        job_count <= job_count + CNT_W'(1);
      end

      if (cmd.scan_init || cmd.pick || cmd.idx_clr || cmd.end_set) begin
        idx <= '0;
      end else if (cmd.scan_rd || cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end

      if (cmd.scan_init) begin
        pick_cnt <= '0;
      end else if (cmd.pick) begin
        pick_cnt <= pick_cnt + IDX_W'(1);
      end

      if (cmd.scan_init || cmd.pick) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end

      if (cmd.pick) begin
        done_flags[best] <= 1'b1;
        run_clock        <= run_clock + TIME_W'(best_burst);
      end

      if (cmd.sum_acc) begin
        wait_total       <= wait_total + TOT_W'(wait_q);
        turnaround_total <= turnaround_total + TOT_W'(turn_cur);
      end

      if (cmd.end_set) begin
        done_flags       <= '0;
        job_count        <= '0;
        run_clock        <= '0;
        wait_total       <= '0;
        turnaround_total <= '0;
      end
    end
  end

  // Min search payload
  always_ff @(posedge clk) begin
    if (take) begin
      best       <= cmp_idx;
      best_burst <= burst_q;
    end
    if (cmd.scan_rd) begin
      cmp_idx <= idx;
    end
  end

  // Averages
  assign dividend = cmd.div_sel ? {turnaround_total, FRAC_W'(0)}
                                : {wait_total, FRAC_W'(0)};

  sjf_div #(
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (job_count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_q <= cmd.div_sel;
    end
    if (div_done) begin
      if (div_sel_q) begin
        avg_t <= quotient[FX_W-1:0];
      end else begin
        avg_w <= quotient[FX_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      job_index         <= JOB_IDX_W'(idx);
      job_burst         <= burst_q;
      wait_time         <= wait_q;
      turnaround_time   <= turn_cur;
      avg_wait_fx       <= stat.idx_last ? avg_w : '0;
      avg_turnaround_fx <= stat.idx_last ? avg_t : '0;
      final_res         <= stat.idx_last;
    end
  end

endmodule

// ===== rtl/sjf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_ctrl
// Controller: sequences load, selection passes, totals, averaging and
// result emission.
// ----------------------------------------------------------------------------
module sjf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               last_job,
  input  sjf_pkg::sjf_stat_t stat,
  output sjf_pkg::sjf_cmd_t  cmd
);
  import sjf_pkg::*;

  sjf_state_t state;
  sjf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && last_job) begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_SCAN_FIN;
        end
      end
      ST_SCAN_FIN: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = stat.pick_last ? ST_SUM_RD : ST_SCAN;
      end
      ST_SUM_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_DIV_W;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_SUM_RD;
        end
      end
      ST_DIV_W: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_W_WAIT;
      end
      ST_DIV_W_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = ST_DIV_T_WAIT;
      end
      ST_DIV_T_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.idx_last) begin
            cmd.end_set = 1'b1;
            state_next  = ST_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/sjf_nonpreemptive_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler for one job set at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, burst, last_job): one item per job,
//   one per cycle. Up to MAX_JOBS bursts are stored; extra ones are dropped.
//   The item with last_job set closes the set and starts scheduling.
//   Output channel (out_valid/out_ready): one item per job in load order,
//   with burst, wait and turnaround times; the last item carries the
//   averages (8 fraction bits, truncated) and final_res.
// Processing for a set of n jobs after the closing item:
//   selection makes n picks, each scanning all stored jobs through the
//   single read port of the burst store; totals read each job back; the
//   two averages run in turn on the one-bit-per-cycle divider; then each
//   result is read and loaded into the output register.
// in_ready is high only while loading; the set is cleared as the last
// result enters the output register, so the next set loads while it waits.
// A stalled receiver holds the output register and pauses emission.
// Reset (rst, synchronous) empties the set and the output register.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sjf_pkg::BURST_W-1:0]   burst,
  input  logic                          last_job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sjf_pkg::JOB_IDX_W-1:0] job_index,
  output logic [sjf_pkg::BURST_W-1:0]   job_burst,
  output logic [sjf_pkg::TIME_W-1:0]    wait_time,
  output logic [sjf_pkg::TIME_W-1:0]    turnaround_time,
  output logic [sjf_pkg::FX_W-1:0]      avg_wait_fx,
  output logic [sjf_pkg::FX_W-1:0]      avg_turnaround_fx,
  output logic                          final_res
);
  import sjf_pkg::*;

  sjf_cmd_t  cmd;
  sjf_stat_t stat;

  // Sequencer
  sjf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .last_job (last_job),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, search, totals, divider, output register
  sjf_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .burst             (burst),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .job_index         (job_index),
    .job_burst         (job_burst),
    .wait_time         (wait_time),
    .turnaround_time   (turnaround_time),
    .avg_wait_fx       (avg_wait_fx),
    .avg_turnaround_fx (avg_turnaround_fx),
    .final_res         (final_res)
  );

endmodule

// ===== test/sjf_nonpreemptive_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_test
// Self-checking bench for the shortest-job-first scheduler. Job sets are
// queued up front and driven on the input channel. A scoreboard
// recomputes the SJF order, the per-job wait and turnaround times and the
// set averages for every closing item. Each output item is then checked
// field by field against the oldest pending report.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler_test;
  import sjf_pkg::*;

  localparam int NJOBS        = MAX_JOBS_DEF;
  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES  = 1500;   // long receiver stall, fills the block
  localparam int DRAIN_CYCLES = 600;    // run-on after the last expected report
  localparam int STALL_LIMIT  = 20000;  // cycles with no handshake at all
  localparam int MAX_PRINTS   = 60;

  // one input item
  typedef struct {
    logic [BURST_W-1:0] burst;
    logic               last;
  } job_item_t;

  // one expected output item
  typedef struct {
    logic [JOB_IDX_W-1:0] index;
    logic [BURST_W-1:0]   burst_len;
    logic [TIME_W-1:0]    wait_tm;
    logic [TIME_W-1:0]    tat;
    logic [FX_W-1:0]      avg_wait;
    logic [FX_W-1:0]      avg_tat;
    logic                 last_res;
  } job_report_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [BURST_W-1:0]   burst     = '0;
  logic                 last_job  = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [JOB_IDX_W-1:0] job_index;
  logic [BURST_W-1:0]   job_burst;
  logic [TIME_W-1:0]    wait_time;
  logic [TIME_W-1:0]    turnaround_time;
  logic [FX_W-1:0]      avg_wait_fx;
  logic [FX_W-1:0]      avg_turnaround_fx;
  logic                 final_res;

  sjf_nonpreemptive_scheduler dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .burst             (burst),
    .last_job          (last_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .job_index         (job_index),
    .job_burst         (job_burst),
    .wait_time         (wait_time),
    .turnaround_time   (turnaround_time),
    .avg_wait_fx       (avg_wait_fx),
    .avg_turnaround_fx (avg_turnaround_fx),
    .final_res         (final_res)
  );

  initial forever #2 clk = ~clk;

  job_item_t   jobs_to_send[$];
  job_report_t reports_due[$];

  // scoreboard copy of the set being loaded
  logic [BURST_W-1:0] set_burst [NJOBS];
  int                 set_size = 0;

  int errors      = 0;
  int items_in    = 0;
  int items_total = 1;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int quiet       = 0;
  bit in_accepted = 1'b0;  // set at the rising edge, read by the driver

  task automatic log_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ERROR %s", $time, msg);
  endtask

  // Store one burst; on the closing item run the SJF pass over the set and
  // queue one report per job in load order. Extra jobs past a full set
  // are dropped, but a closing item still ends the set.
  task automatic take_job(input logic [BURST_W-1:0] b, input logic last);
    bit                 taken    [NJOBS];
    logic [TIME_W-1:0]  start_at [NJOBS];
    logic [TIME_W-1:0]  now;
    logic [TOT_W-1:0]   wait_sum;
    logic [TOT_W-1:0]   tat_sum;
    logic [DIV_W-1:0]   quot;
    int                 best;
    job_report_t        r;
    if (set_size < NJOBS) begin
      set_burst[set_size] = b;
      set_size++;
    end
    if (!last) return;
    now = '0;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int p = 0; p < set_size; p++) begin
      best = -1;
      // strict less-than: ties keep the lowest index, zero bursts are eligible
      for (int i = 0; i < set_size; i++) begin
        if (!taken[i] && (best < 0 || set_burst[i] < set_burst[best])) best = i;
      end
      taken[best]    = 1'b1;
      start_at[best] = now;
      now            = now + set_burst[best];
    end
    wait_sum = '0;
    tat_sum  = '0;
    for (int i = 0; i < set_size; i++) begin
      r.index     = JOB_IDX_W'(i);
      r.burst_len = set_burst[i];
      r.wait_tm   = start_at[i];
      r.tat       = start_at[i] + set_burst[i];
      r.avg_wait  = '0;
      r.avg_tat   = '0;
      r.last_res  = 1'b0;
      wait_sum    = wait_sum + r.wait_tm;
      tat_sum     = tat_sum + r.tat;
      if (i == set_size - 1) begin
        quot       = {wait_sum, {FRAC_W{1'b0}}} / DIV_W'(set_size);
        r.avg_wait = quot[FX_W-1:0];
        quot       = {tat_sum, {FRAC_W{1'b0}}} / DIV_W'(set_size);
        r.avg_tat  = quot[FX_W-1:0];
        r.last_res = 1'b1;
      end
      reports_due.push_back(r);
    end
    set_size = 0;
  endtask

  task automatic check_report();
    job_report_t e;
    if (reports_due.size() == 0) begin
      log_error($sformatf("unexpected result, job_index %0d", job_index));
      return;
    end
    e = reports_due.pop_front();
    if (job_index !== e.index)
      log_error($sformatf("job_index %0d, want %0d", job_index, e.index));
    if (job_burst !== e.burst_len)
      log_error($sformatf("job %0d burst %0d, want %0d", e.index, job_burst, e.burst_len));
    if (wait_time !== e.wait_tm)
      log_error($sformatf("job %0d wait %0d, want %0d", e.index, wait_time, e.wait_tm));
    if (turnaround_time !== e.tat)
      log_error($sformatf("job %0d turnaround %0d, want %0d",
                          e.index, turnaround_time, e.tat));
    if (avg_wait_fx !== e.avg_wait)
      log_error($sformatf("job %0d avg wait 0x%0h, want 0x%0h",
                          e.index, avg_wait_fx, e.avg_wait));
    if (avg_turnaround_fx !== e.avg_tat)
      log_error($sformatf("job %0d avg turnaround 0x%0h, want 0x%0h",
                          e.index, avg_turnaround_fx, e.avg_tat));
    if (final_res !== e.last_res)
      log_error($sformatf("job %0d final_res %b, want %b", e.index, final_res, e.last_res));
  endtask

  // Three idle phases by input progress: sender light / receiver heavy,
  // then swapped, then neither side idles at random.
  function automatic int phase_now();
    return (items_in * 3) / items_total;
  endfunction

  function automatic int send_idle_pct();
    case (phase_now())
      0:       return 7;
      1:       return 88;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (phase_now())
      0:       return 88;
      1:       return 7;
      default: return 0;
    endcase
  endfunction

  task automatic add_job(input logic [BURST_W-1:0] b, input logic last);
    job_item_t it;
    it.burst = b;
    it.last  = last;
    jobs_to_send.push_back(it);
  endtask

  function automatic logic [BURST_W-1:0] pick_burst();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return BURST_W'($urandom_range(7));  // small, many ties
    if (sel < 35) return '1;
    if (sel < 40) return '0;
    return BURST_W'($urandom());
  endfunction

  // Monitor and scoreboard: sample both handshakes at the rising edge.
  always @(posedge clk) begin
    in_accepted = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) check_report();
      if (in_valid && in_ready) begin
        in_accepted = 1'b1;
        items_in++;
        take_job(burst, last_job);
      end
    end
  end

  // Input driver: a new item only once the current one is taken (or none).
  always @(negedge clk) begin : drive_jobs
    job_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (jobs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        nxt = jobs_to_send.pop_front();
        in_valid <= 1'b1;
        burst    <= nxt.burst;
        last_job <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output ready. On entering the last phase the receiver stalls for a long
  // stretch while the sender keeps offering, so in_ready has to drop.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase_now() == 2) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Watchdog: too long without any handshake means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("sjf_nonpreemptive_scheduler_test: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int n;
    int sel;
    int random_items;
    // single zero-burst job, single max-burst job
    add_job('0, 1'b1);
    add_job('1, 1'b1);
    // ties and zero bursts: the zero jobs go first, lowest index wins
    add_job(16'd5, 1'b0);
    add_job(16'd0, 1'b0);
    add_job(16'd5, 1'b0);
    add_job(16'd0, 1'b0);
    add_job(16'd3, 1'b1);
    // full set of max bursts, then a dropped job and a dropped closing job
    for (int i = 0; i < NJOBS; i++) add_job('1, 1'b0);
    add_job(16'h1234, 1'b0);
    add_job(16'h0000, 1'b1);

    // random sets, mostly short; some full and some overflowing
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 65)      n = $urandom_range(5, 1);
      else if (sel < 88) n = $urandom_range(12, 6);
      else if (sel < 96) n = NJOBS;
      else               n = $urandom_range(NJOBS + 3, NJOBS + 1);
      for (int j = 0; j < n; j++) add_job(pick_burst(), j == n - 1);
      random_items += n;
    end
    items_total = jobs_to_send.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (jobs_to_send.size() != 0 || in_valid) @(negedge clk);
    while (reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("sjf_nonpreemptive_scheduler_test: done, clean");
    end else begin
      $display("sjf_nonpreemptive_scheduler_test: done, errors");
    end
    $finish;
  end

endmodule
